### hw/rtl/dtdsc_pkg.sv
// ----------------------------------------------------------------------------
// dtdsc_pkg
// Shared types, constants and command codes for the binary64 to decimal
// scientific converter.
// ----------------------------------------------------------------------------
package dtdsc_pkg;

	localparam int unsigned SigW  = 64;
	localparam int unsigned FracW = 52;
	localparam int unsigned ExpW  = 12;
	localparam int unsigned DigW  = 54;
	localparam int unsigned KW    = 5;
	localparam int unsigned NumPow = 20;

	localparam logic [10:0]     EXP_BIAS  = 11'd1023;
	localparam logic [SigW-1:0] U64_TENTH = 64'd1844674407370955161;
	localparam logic [SigW-1:0] LIMIT_POS = 64'd10000000000000000;
	localparam logic [SigW-1:0] LIMIT_NEG = 64'd1000000000000000;

	typedef logic [3:0] op_t;

	localparam op_t OP_NOP         = 4'd0;
	localparam op_t OP_LOAD        = 4'd1;
	localparam op_t OP_EXP_STEP    = 4'd2;
	localparam op_t OP_CNT_CLR     = 4'd3;
	localparam op_t OP_CNT_STEP    = 4'd4;
	localparam op_t OP_E10_INIT    = 4'd5;
	localparam op_t OP_E10_ADD     = 4'd6;
	localparam op_t OP_UP_SHIFT    = 4'd7;
	localparam op_t OP_Q_INC_SHIFT = 4'd8;
	localparam op_t OP_MUL10       = 4'd9;
	localparam op_t OP_Q           = 4'd10;
	localparam op_t OP_FLOOR       = 4'd11;
	localparam op_t OP_DOWN_STEP   = 4'd12;
	localparam op_t OP_Q_LAST      = 4'd13;
	localparam op_t OP_ROUND       = 4'd14;
	localparam op_t OP_OUT         = 4'd15;

	// controller to datapath
	typedef struct packed {
		op_t  op;
		logic div_start;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_zero;
		logic exp_done;
		logic cnt_more;
		logic e2_pos;
		logic e2_neg;
		logic sig_msb;
		logic sig_zero;
		logic sig_le_tenth;
		logic sig_gt_limit;
		logic div_done;
		logic rem_zero;
		logic out_free;
	} stat_t;

	// powers of ten, 10^0 .. 10^19
	function automatic logic [SigW-1:0] pow10(input logic [KW-1:0] k);
		logic [SigW-1:0] p;
		p = 64'd1;
		case (k)
			5'd0:  p = 64'd1;
			5'd1:  p = 64'd10;
			5'd2:  p = 64'd100;
			5'd3:  p = 64'd1000;
			5'd4:  p = 64'd10000;
			5'd5:  p = 64'd100000;
			5'd6:  p = 64'd1000000;
			5'd7:  p = 64'd10000000;
			5'd8:  p = 64'd100000000;
			5'd9:  p = 64'd1000000000;
			5'd10: p = 64'd10000000000;
			5'd11: p = 64'd100000000000;
			5'd12: p = 64'd1000000000000;
			5'd13: p = 64'd10000000000000;
			5'd14: p = 64'd100000000000000;
			5'd15: p = 64'd1000000000000000;
			5'd16: p = 64'd10000000000000000;
			5'd17: p = 64'd100000000000000000;
			5'd18: p = 64'd1000000000000000000;
			5'd19: p = 64'd10000000000000000000;
			default: p = 64'd0;
		endcase
		return p;
	endfunction

endpackage

### hw/rtl/dtdsc_if.sv
// ----------------------------------------------------------------------------
// dtdsc_if
// Valid/ready channels: input word (raw binary64) and result word.
// ----------------------------------------------------------------------------
interface dtdsc_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value_bits;

	modport source (output valid, output value_bits, input ready);
	modport sink (input valid, input value_bits, output ready);
endinterface

interface dtdsc_out_if;
	logic               valid;
	logic               ready;
	logic               is_zero;
	logic               is_negative;
	logic [53:0]        digit_value;
	logic signed [11:0] decimal_exponent;

	modport source (output valid, output is_zero, output is_negative,
		output digit_value, output decimal_exponent, input ready);
	modport sink (input valid, input is_zero, input is_negative,
		input digit_value, input decimal_exponent, output ready);
endinterface

### hw/rtl/double_to_decimal_sci_convert_unit.sv
// ----------------------------------------------------------------------------
// double_to_decimal_sci_convert_unit
// Converts a raw binary64 pattern into sign, decimal digits and a power of ten.
// ----------------------------------------------------------------------------
// Usage:
//   din  carries one word: the 64-bit binary64 pattern (value_bits).
//   dout carries one result word per input: is_zero, is_negative,
//   digit_value and decimal_exponent.
//   Words move when valid and ready are both high at a rising clk edge.
// Conversion:
//   One word is converted at a time. The time per word grows with the
//   fraction steps (up to 52), the digit count, the binary exponent and
//   the number of divides by ten, which come from the exponent migration,
//   rounding and zero stripping.
// Reset:
//   arst_n clears the controller, the divider sequencing and the result
//   valid; nothing else.
// Stalls:
//   A finished word sits in the result register; the next input is taken
//   while it waits. A second finished word holds until dout.ready frees it.
// ----------------------------------------------------------------------------
module double_to_decimal_sci_convert_unit (
	input  logic         clk,
	input  logic         arst_n,
	dtdsc_in_if.sink     din,
	dtdsc_out_if.source  dout
);

	dtdsc_pkg::cmd_t  cmd;
	dtdsc_pkg::stat_t st;

	dtdsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.st       (st),
		.cmd      (cmd)
	);

	dtdsc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value_bits (din.value_bits),
		.st         (st),
		.dout       (dout)
	);

endmodule

### hw/rtl/dtdsc_div10.sv
// ----------------------------------------------------------------------------
// dtdsc_div10
// Multicycle 64-bit divide by ten: restoring, eight quotient bits a cycle.
// ----------------------------------------------------------------------------
module dtdsc_div10 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic        done,
	output logic [63:0] q,
	output logic [3:0]  r
);

	logic [63:0] num_q;
	logic [63:0] quo_q;
	logic [3:0]  rem_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [3:0]  rem_n;
	logic [7:0]  qb_n;

	// eight restoring steps on the top dividend byte
	always_comb begin
		logic [4:0] t;
		rem_n = rem_q;
		qb_n  = '0;
		for (int i = 0; i < 8; i++) begin
			t = {rem_n, num_q[63-i]};
			if (t >= 5'd10) begin
				rem_n    = 4'(t - 5'd10);
				qb_n[7-i] = 1'b1;
			end else begin
				rem_n = t[3:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd8;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= x;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[55:0], 8'd0};
			quo_q <= {quo_q[55:0], qb_n};
			rem_q <= rem_n;
		end
	end

	assign done = done_q;
	assign q    = quo_q;
	assign r    = rem_q;

endmodule

### hw/rtl/dtdsc_dp.sv
// ----------------------------------------------------------------------------
// dtdsc_dp
// Datapath: significand, weight, exponents, digit counter, divider and the
// result register.
// ----------------------------------------------------------------------------
module dtdsc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  dtdsc_pkg::cmd_t     cmd,
	input  logic [63:0]         value_bits,
	output dtdsc_pkg::stat_t    st,
	dtdsc_out_if.source         dout
);

	logic [63:0]        bits_q;
	logic [63:0]        sig_q;
	logic [63:0]        wt_q;
	logic [63:0]        floor_q;
	logic [5:0]         fcnt_q;
	logic [4:0]         k_q;
	logic [3:0]         last_q;
	logic signed [11:0] e2_q;
	logic signed [11:0] e10_q;
	logic               zero_q;
	logic               ovalid_q;

	logic               div_done;
	logic [63:0]        div_q;
	logic [3:0]         div_r;

	logic [51:0]        fmask;
	logic [63:0]        exp_acc;
	logic [63:0]        exp_wt;
	logic [63:0]        dn_sh;
	logic [63:0]        limit;

	dtdsc_div10 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.x      (sig_q),
		.done   (div_done),
		.q      (div_q),
		.r      (div_r)
	);

	// fraction expansion step
	always_comb begin
		fmask   = 52'((53'd1 << fcnt_q) - 53'd1);
		exp_acc = sig_q;
		exp_wt  = wt_q >> 1;
		if (sig_q <= dtdsc_pkg::U64_TENTH) begin
			exp_acc = (sig_q << 3) + (sig_q << 1);
			exp_wt  = (wt_q << 2) + wt_q;
		end
		if (fcnt_q != 6'd0 && bits_q[6'(fcnt_q - 6'd1)])
			exp_acc = exp_acc + exp_wt;
	end

	assign dn_sh = sig_q >> 1;
	assign limit = e10_q[11] ? dtdsc_pkg::LIMIT_NEG : dtdsc_pkg::LIMIT_POS;

	// status
	always_comb begin
		st.in_zero      = (bits_q[62:0] == 63'd0);
		st.exp_done     = (fcnt_q == 6'd0) || ((bits_q[51:0] & fmask) == 52'd0);
		st.cnt_more     = (k_q < 5'(dtdsc_pkg::NumPow)) &&
			(sig_q >= dtdsc_pkg::pow10(k_q));
		st.e2_pos       = !e2_q[11] && (e2_q != 12'sd0);
		st.e2_neg       = e2_q[11];
		st.sig_msb      = sig_q[63];
		st.sig_zero     = (sig_q == 64'd0);
		st.sig_le_tenth = (sig_q <= dtdsc_pkg::U64_TENTH);
		st.sig_gt_limit = (sig_q > limit);
		st.div_done     = div_done;
		st.rem_zero     = (div_r == 4'd0);
		st.out_free     = !ovalid_q || dout.ready;
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.op == dtdsc_pkg::OP_OUT)
				ovalid_q <= 1'b1;
			else if (dout.ready)
				ovalid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			dtdsc_pkg::OP_LOAD: begin
				bits_q <= value_bits;
				sig_q  <= 64'd1;
				wt_q   <= 64'd1;
				fcnt_q <= 6'(dtdsc_pkg::FracW);
				e2_q   <= $signed({1'b0, value_bits[62:52]}) - $signed({1'b0, dtdsc_pkg::EXP_BIAS});
				e10_q  <= '0;
				last_q <= '0;
				zero_q <= (value_bits[62:0] == 63'd0);
			end
			dtdsc_pkg::OP_EXP_STEP: begin
				sig_q  <= exp_acc;
				wt_q   <= exp_wt;
				fcnt_q <= fcnt_q - 6'd1;
			end
			dtdsc_pkg::OP_CNT_CLR:  k_q <= '0;
			dtdsc_pkg::OP_CNT_STEP: k_q <= k_q + 5'd1;
			dtdsc_pkg::OP_E10_INIT: e10_q <= 12'sd1 - $signed({7'd0, k_q});
			dtdsc_pkg::OP_E10_ADD:  e10_q <= e10_q + $signed({7'd0, k_q}) - 12'sd1;
			dtdsc_pkg::OP_UP_SHIFT: begin
				sig_q <= sig_q << 1;
				e2_q  <= e2_q - 12'sd1;
			end
			dtdsc_pkg::OP_Q_INC_SHIFT: begin
				sig_q <= div_q << 1;
				e2_q  <= e2_q - 12'sd1;
				e10_q <= e10_q + 12'sd1;
			end
			dtdsc_pkg::OP_MUL10: sig_q <= (sig_q << 3) + (sig_q << 1);
			dtdsc_pkg::OP_Q:     sig_q <= div_q;
			dtdsc_pkg::OP_FLOOR: floor_q <= div_q;
			dtdsc_pkg::OP_DOWN_STEP: begin
				e2_q <= e2_q + 12'sd1;
				if (dn_sh <= dtdsc_pkg::U64_TENTH && dn_sh > floor_q) begin
					sig_q <= (dn_sh << 3) + (dn_sh << 1);
					e10_q <= e10_q - 12'sd1;
				end else begin
					sig_q <= dn_sh;
				end
			end
			dtdsc_pkg::OP_Q_LAST: begin
				sig_q  <= div_q;
				last_q <= div_r;
			end
			dtdsc_pkg::OP_ROUND: begin
				if (last_q > 4'd4)
					sig_q <= sig_q + 64'd1;
			end
			dtdsc_pkg::OP_OUT: begin
				dout.is_zero          <= zero_q;
				dout.is_negative      <= zero_q ? 1'b0 : bits_q[63];
				dout.digit_value      <= zero_q ? '0 : sig_q[53:0];
				dout.decimal_exponent <= zero_q ? '0 : e10_q;
			end
			default: begin
			end
		endcase
	end

	assign dout.valid = ovalid_q;

endmodule

### hw/rtl/dtdsc_ctrl.sv
// ----------------------------------------------------------------------------
// dtdsc_ctrl
// Controller: sequences expansion, exponent migration, rounding and
// zero stripping through datapath commands.
// ----------------------------------------------------------------------------
module dtdsc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dtdsc_pkg::stat_t st,
	output dtdsc_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHK   = 4'd1;
	localparam logic [3:0] S_EXP   = 4'd2;
	localparam logic [3:0] S_CNT1  = 4'd3;
	localparam logic [3:0] S_UP    = 4'd4;
	localparam logic [3:0] S_UPDIV = 4'd5;
	localparam logic [3:0] S_CNT2  = 4'd6;
	localparam logic [3:0] S_MUL   = 4'd7;
	localparam logic [3:0] S_DIVA  = 4'd8;
	localparam logic [3:0] S_DIVA2 = 4'd9;
	localparam logic [3:0] S_DIVB  = 4'd10;
	localparam logic [3:0] S_DOWN  = 4'd11;
	localparam logic [3:0] S_RND   = 4'd12;
	localparam logic [3:0] S_RDIV  = 4'd13;
	localparam logic [3:0] S_STRIP = 4'd14;
	localparam logic [3:0] S_SDIV  = 4'd15;

	logic [3:0] state_q;
	logic [3:0] state_n;
	logic       done_q;
	logic       done_n;

	assign in_ready = (state_q == S_IDLE) && !done_q;

	// next state and command
	always_comb begin
		state_n       = state_q;
		done_n        = done_q;
		cmd.op        = dtdsc_pkg::OP_NOP;
		cmd.div_start = 1'b0;
		if (done_q) begin
			// hold the finished word until the result register frees up
			if (st.out_free) begin
				cmd.op = dtdsc_pkg::OP_OUT;
				done_n = 1'b0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd.op  = dtdsc_pkg::OP_LOAD;
						state_n = S_CHK;
					end
				end
				S_CHK: begin
					if (st.in_zero) begin
						done_n  = 1'b1;
						state_n = S_IDLE;
					end else begin
						state_n = S_EXP;
					end
				end
				S_EXP: begin
					if (st.exp_done) begin
						cmd.op = dtdsc_pkg::OP_CNT_CLR;
						if (st.e2_pos)      state_n = S_CNT1;
						else if (st.e2_neg) state_n = S_MUL;
						else                state_n = S_RND;
					end else begin
						cmd.op = dtdsc_pkg::OP_EXP_STEP;
					end
				end
				S_CNT1: begin
					if (st.cnt_more) begin
						cmd.op = dtdsc_pkg::OP_CNT_STEP;
					end else begin
						cmd.op  = dtdsc_pkg::OP_E10_INIT;
						state_n = S_UP;
					end
				end
				S_UP: begin
					if (!st.e2_pos) begin
						cmd.op  = dtdsc_pkg::OP_CNT_CLR;
						state_n = S_CNT2;
					end else if (st.sig_msb) begin
						cmd.div_start = 1'b1;
						state_n       = S_UPDIV;
					end else begin
						cmd.op = dtdsc_pkg::OP_UP_SHIFT;
					end
				end
				S_UPDIV: begin
					if (st.div_done) begin
						cmd.op  = dtdsc_pkg::OP_Q_INC_SHIFT;
						state_n = S_UP;
					end
				end
				S_CNT2: begin
					if (st.cnt_more) begin
						cmd.op = dtdsc_pkg::OP_CNT_STEP;
					end else begin
						cmd.op  = dtdsc_pkg::OP_E10_ADD;
						state_n = S_RND;
					end
				end
				S_MUL: begin
					if (!st.sig_zero && st.sig_le_tenth) begin
						cmd.op = dtdsc_pkg::OP_MUL10;
					end else begin
						cmd.div_start = 1'b1;
						state_n       = S_DIVA;
					end
				end
				S_DIVA: begin
					if (st.div_done) begin
						cmd.op  = dtdsc_pkg::OP_Q;
						state_n = S_DIVA2;
					end
				end
				S_DIVA2: begin
					cmd.div_start = 1'b1;
					state_n       = S_DIVB;
				end
				S_DIVB: begin
					if (st.div_done) begin
						cmd.op  = dtdsc_pkg::OP_FLOOR;
						state_n = S_DOWN;
					end
				end
				S_DOWN: begin
					if (st.e2_neg) cmd.op = dtdsc_pkg::OP_DOWN_STEP;
					else           state_n = S_RND;
				end
				S_RND: begin
					if (st.sig_gt_limit) begin
						cmd.div_start = 1'b1;
						state_n       = S_RDIV;
					end else begin
						cmd.op  = dtdsc_pkg::OP_ROUND;
						state_n = S_STRIP;
					end
				end
				S_RDIV: begin
					if (st.div_done) begin
						cmd.op  = dtdsc_pkg::OP_Q_LAST;
						state_n = S_RND;
					end
				end
				S_STRIP: begin
					if (st.sig_zero) begin
						done_n  = 1'b1;
						state_n = S_IDLE;
					end else begin
						cmd.div_start = 1'b1;
						state_n       = S_SDIV;
					end
				end
				S_SDIV: begin
					if (st.div_done) begin
						if (st.rem_zero) begin
							cmd.op  = dtdsc_pkg::OP_Q;
							state_n = S_STRIP;
						end else begin
							done_n  = 1'b1;
							state_n = S_IDLE;
						end
					end
				end
				default: state_n = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= done_n;
		end
	end

endmodule
